// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned DivW     = DataW + FracBits;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;

  typedef enum logic [3:0] {
    OpAdd      = 4'd0,
    OpSub      = 4'd1,
    OpMul      = 4'd2,
    OpDiv      = 4'd3,
    OpMin      = 4'd4,
    OpMax      = 4'd5,
    OpInc      = 4'd6,
    OpDec      = 4'd7,
    OpIntToFix = 4'd8,
    OpFixToInt = 4'd9
  } opcode_e;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic [3:0]              opcode;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic                    gt;
    logic                    lt;
    logic                    eq;
    logic                    dz;
  } op_t;

  typedef struct packed {
    logic signed [DataW-1:0] res;
    logic                    gt;
    logic                    lt;
    logic                    eq;
    logic                    dz;
  } res_t;

endpackage

// ===== rtl/fpa_front.sv =====
module fpa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [3:0]                        opcode_i,
  input  logic signed [fpa_pkg::DataW-1:0] a_raw_i,
  input  logic signed [fpa_pkg::DataW-1:0] b_raw_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output fpa_pkg::op_t                      op_o
);
  import fpa_pkg::*;

  // Queue between the front and the back part.
  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  op_t              cls;
  logic             do_push, do_pop;

  always_comb begin
    cls.opcode = opcode_i;
    cls.a      = a_raw_i;
    cls.b      = b_raw_i;
    cls.gt     = a_raw_i > b_raw_i;
    cls.lt     = a_raw_i < b_raw_i;
    cls.eq     = a_raw_i == b_raw_i;
    cls.dz     = (opcode_i == OpDiv) && (b_raw_i == '0);
  end

  assign full_o  = cnt_q == (QPtrW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && ready_i;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/fpa_back.sv =====
module fpa_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  fpa_pkg::op_t op_i,
  output logic         valid_o,
  input  logic         ready_i,
  output fpa_pkg::res_t res_o
);
  import fpa_pkg::*;

  localparam int unsigned Stages = DivW + 2;
  localparam int unsigned MagW   = DivW;

  // Stage 0: operand prep; stages 1..DivW: one quotient bit each; last: select.
  logic [Stages-1:0]          vld_q;
  op_t                        op_q   [Stages];
  logic signed [DataW-1:0]    simp_q [Stages];
  logic [2*DataW-1:0]         prod_q;
  logic [2*DataW-1:0]         prod_s [Stages];
  logic [MagW-1:0]            rem_q  [Stages];
  logic [MagW-1:0]            num_q  [Stages];
  logic [DataW-1:0]           den_q  [Stages];
  logic                       neg_q  [Stages];
  res_t                       out_q;
  logic                       out_vld_q;
  logic                       adv;

  assign adv     = !out_vld_q || ready_i || !vld_q[Stages-1];
  assign ready_o = adv;
  assign valid_o = out_vld_q;
  assign res_o   = out_q;

  logic signed [DataW-1:0] simp;
  logic [MagW-1:0] anum;
  logic [DataW-1:0] bmag;

  always_comb begin
    anum = (op_i.a[DataW-1] ? -MagW'(op_i.a) : MagW'(op_i.a)) << FracBits;
    bmag = op_i.b[DataW-1] ? DataW'(-op_i.b) : DataW'(op_i.b);
    case (op_i.opcode)
      OpAdd:      simp = op_i.a + op_i.b;
      OpSub:      simp = op_i.a - op_i.b;
      OpMin:      simp = op_i.lt ? op_i.a : op_i.b;
      OpMax:      simp = op_i.gt ? op_i.a : op_i.b;
      OpInc:      simp = op_i.a + 1;
      OpDec:      simp = op_i.a - 1;
      OpIntToFix: simp = op_i.a << FracBits;
      OpFixToInt: simp = op_i.a >>> FracBits;
      default:    simp = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[Stages-2:0], valid_i};
        // Hold a waiting result until it is popped.
        if (vld_q[Stages-1]) begin
          out_vld_q <= 1'b1;
        end else if (ready_i) begin
          out_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q[0]   <= op_i;
      simp_q[0] <= simp;
      prod_q    <= op_i.a * op_i.b;
      prod_s[0] <= '0;
      rem_q[0]  <= '0;
      num_q[0]  <= anum;
      den_q[0]  <= bmag;
      neg_q[0]  <= op_i.a[DataW-1] ^ op_i.b[DataW-1];
      for (int i = 1; i < Stages; i++) begin
        op_q[i]   <= op_q[i-1];
        simp_q[i] <= simp_q[i-1];
        den_q[i]  <= den_q[i-1];
        neg_q[i]  <= neg_q[i-1];
        prod_s[i] <= (i == 1) ? prod_q : prod_s[i-1];
      end
      // Restoring division, one quotient bit per stage; num shifts in quotient bits.
      for (int i = 1; i <= DivW; i++) begin
        logic [MagW:0] trial;
        trial = {rem_q[i-1], num_q[i-1][MagW-1]} - (MagW+1)'(den_q[i-1]);
        if (!trial[MagW]) begin
          rem_q[i] <= trial[MagW-1:0];
          num_q[i] <= {num_q[i-1][MagW-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i-1][MagW-2:0], num_q[i-1][MagW-1]};
          num_q[i] <= {num_q[i-1][MagW-2:0], 1'b0};
        end
      end
      rem_q[Stages-1] <= rem_q[Stages-2];
      num_q[Stages-1] <= num_q[Stages-2];
      if (vld_q[Stages-1]) begin
        out_q.gt <= op_q[Stages-1].gt;
        out_q.lt <= op_q[Stages-1].lt;
        out_q.eq <= op_q[Stages-1].eq;
        out_q.dz <= op_q[Stages-1].dz;
        case (op_q[Stages-1].opcode)
          OpMul: out_q.res <= DataW'($signed(prod_s[Stages-1]) >>> FracBits);
          OpDiv: begin
            if (op_q[Stages-1].dz) begin
              out_q.res <= '0;
            end else if (neg_q[Stages-1]) begin
              out_q.res <= DataW'(-num_q[Stages-1]);
            end else begin
              out_q.res <= DataW'(num_q[Stages-1]);
            end
          end
          default: out_q.res <= simp_q[Stages-1];
        endcase
      end
    end
  end

endmodule

// ===== rtl/fixed_point_alu_core.sv =====
// Q24.8 fixed-point ALU: add, sub, mul, div, min, max, inc, dec and integer
// conversions on 32-bit signed raw operands, with compare flags on every item.
// Accepts one item per cycle while full is low; the back pipeline's depth is
// set by the divider, which takes one quotient bit per stage.
module fixed_point_alu_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [3:0]                        opcode_i,
  input  logic signed [fpa_pkg::DataW-1:0] a_raw_i,
  input  logic signed [fpa_pkg::DataW-1:0] b_raw_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [fpa_pkg::DataW-1:0] result_raw_o,
  output logic                              a_greater_o,
  output logic                              a_less_o,
  output logic                              a_equal_o,
  output logic                              divide_by_zero_o
);
  import fpa_pkg::*;

  op_t  op;
  res_t res;
  logic op_vld, op_rdy, res_vld;

  fpa_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .opcode_i, .a_raw_i, .b_raw_i,
    .valid_o(op_vld), .ready_i(op_rdy), .op_o(op)
  );

  fpa_back u_back (
    .clk_i, .rst_ni, .valid_i(op_vld), .ready_o(op_rdy), .op_i(op),
    .valid_o(res_vld), .ready_i(pop), .res_o(res)
  );

  assign empty            = !res_vld;
  assign result_raw_o     = res.res;
  assign a_greater_o      = res.gt;
  assign a_less_o         = res.lt;
  assign a_equal_o        = res.eq;
  assign divide_by_zero_o = res.dz;

endmodule

// ===== rtl/fpa_checker.sv =====
module fpa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic a_greater_o,
  input logic a_less_o,
  input logic a_equal_o,
  input logic divide_by_zero_o,
  input logic signed [fpa_pkg::DataW-1:0] result_raw_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $onehot({a_greater_o, a_less_o, a_equal_o}))
    else $error("compare flags not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && divide_by_zero_o) |-> (result_raw_o == '0))
    else $error("divide by zero result not zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_raw_o))
    else $error("waiting result changed");
endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (.*);

// ===== tb/sv/tb_fixed_point_alu_core.sv =====
`timescale 1ns / 100ps

module tb_fixed_point_alu_core;
  import fpa_pkg::*;

  typedef struct {
    logic signed [31:0] res;
    logic gt;
    logic lt;
    logic eq;
    logic dz;
  } alu_out_t;

  int n_errors = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  class alu_scoreboard;
    alu_out_t pending_q[$];

    function automatic alu_out_t compute(logic [3:0] op, logic signed [31:0] a,
                                         logic signed [31:0] b);
      alu_out_t r;
      logic signed [63:0] wide;
      logic signed [63:0] num;
      r.res = '0;
      r.dz  = 1'b0;
      r.gt  = a > b;
      r.lt  = a < b;
      r.eq  = a == b;
      case (op)
        OpAdd: r.res = a + b;
        OpSub: r.res = a - b;
        OpMul: begin
          wide  = 64'(a) * 64'(b);
          r.res = 32'(wide >>> FracBits);
        end
        OpDiv: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            num   = 64'(a) <<< FracBits;
            wide  = num / 64'(b);
            r.res = 32'(wide);
          end
        end
        OpMin: r.res = (a < b) ? a : b;
        OpMax: r.res = (a > b) ? a : b;
        OpInc: r.res = a + 32'sd1;
        OpDec: r.res = a - 32'sd1;
        OpIntToFix: r.res = a <<< FracBits;
        OpFixToInt: r.res = a >>> FracBits;
        default: r.res = '0;
      endcase
      return r;
    endfunction

    function void note_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      pending_q.push_back(compute(op, a, b));
    endfunction

    task automatic check_result(alu_out_t got);
      alu_out_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_q.pop_front();
        if (got.res !== want.res)
          report_mismatch($sformatf("result %h, want %h", got.res, want.res));
        if (got.gt !== want.gt) report_mismatch("a_greater");
        if (got.lt !== want.lt) report_mismatch("a_less");
        if (got.eq !== want.eq) report_mismatch("a_equal");
        if (got.dz !== want.dz) report_mismatch("divide_by_zero");
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [3:0] opcode_i = '0;
  logic signed [31:0] a_raw_i = '0;
  logic signed [31:0] b_raw_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] result_raw_o;
  logic a_greater_o, a_less_o, a_equal_o, divide_by_zero_o;

  alu_scoreboard sb = new();
  bit stim_done = 1'b0;

  fixed_point_alu_core DUT (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .a_raw_i, .b_raw_i,
    .empty, .pop, .result_raw_o, .a_greater_o, .a_less_o, .a_equal_o,
    .divide_by_zero_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push     <= 1'b1;
    opcode_i <= op;
    a_raw_i  <= a;
    b_raw_i  <= b;
    do @(posedge clk_i); while (full);
    sb.note_item(op, a, b);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $signed($urandom_range(2047)) - 1024;
      4: return $signed($urandom_range(65535)) - 32768;
      default: return $signed($urandom());
    endcase
  endfunction

  // directed corners then random items
  initial begin
    logic signed [31:0] a, b;
    logic [3:0] op;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < 16; k++) begin
      send_item(4'(k), 32'sh8000_0000, 32'sh7fff_ffff);
    end
    send_item(OpDiv, 32'sh0000_0100, 32'sh0);
    send_item(OpDiv, 32'sh8000_0000, 32'shffff_ffff);
    send_item(OpMul, 32'sh8000_0000, 32'sh8000_0000);
    send_item(OpMul, 32'shffff_ff01, 32'sh0000_0080);
    send_item(OpDiv, 32'shffff_fd00, 32'sh0000_0700);
    send_item(OpAdd, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(OpMin, 32'sh1234, 32'sh1234);
    send_item(OpFixToInt, 32'shffff_ff80, 32'sh0);
    // hold until everything has drained
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    for (int n = 0; n < 2000; n++) begin
      op = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      a  = pick_operand();
      b  = ($urandom_range(9) == 0) ? a : pick_operand();
      if (op == OpDiv && $urandom_range(7) == 0) b = '0;
      send_item(op, a, b);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    alu_out_t got;
    forever begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty || !rst_ni);
      got.res = result_raw_o;
      got.gt  = a_greater_o;
      got.lt  = a_less_o;
      got.eq  = a_equal_o;
      got.dz  = divide_by_zero_o;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    while (!(stim_done && sb.pending_q.size() == 0)) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[fixed_point_alu_core] OK");
    end else begin
      $display("[fixed_point_alu_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fixed_point_alu_core] ERROR");
    $finish;
  end

endmodule
